FILE: rtl/sorted_priority_queue_macros.svh
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// plain property under the block clock
`define SPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define SPQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SPQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/spq_pkg.sv
`timescale 1ns / 1ps
package spq_pkg;

  localparam int unsigned DEPTH_DEF       = 64;
  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned OCC_WIDTH       = 7;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } spq_cmd_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } spq_status_e;

  typedef struct packed {
    logic ins;
    logic rem;
  } spq_ctrl_t;

endpackage

FILE: rtl/sorted_priority_queue.sv
`timescale 1ns / 1ps
// Sorted priority queue built as a row of DEPTH cells, one stored value per cell, kept in
// ascending signed order with cell 0 holding the smallest. The command and value of each
// transfer are broadcast to every cell; each cell compares its value with the new one and,
// in the same cycle, either keeps its value, takes the new value or takes a neighbor's, so
// each insert or remove is done as the item is accepted and one item is accepted every cycle while
// the result side keeps up. The result is held in an output register and appears in the cycle
// after acceptance; a new item is accepted whenever that register is empty or being drained.
// Equal values leave in arrival order. An insert into a full queue returns status 1 and a
// remove from an empty queue status 2, both leaving the contents unchanged; removed_value
// is zero unless a remove succeeds. Occupancy reports the low 7 bits of the count.
module sorted_priority_queue #(
  parameter int unsigned DEPTH       = spq_pkg::DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = spq_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          command_i,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [VALUE_WIDTH-1:0] removed_value_o,
  output logic [1:0]                    status_o,
  output logic [spq_pkg::OCC_WIDTH-1:0] occupancy_o
);
  import spq_pkg::*;

  `include "sorted_priority_queue_macros.svh"

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic signed [VALUE_WIDTH-1:0] cell_value [DEPTH];
  logic                          cell_greater [DEPTH];

  logic [CW-1:0]                 count_q, count_d;
  logic                          out_valid_q;
  logic signed [VALUE_WIDTH-1:0] removed_q, removed_d;
  spq_status_e                   status_q, status_d;
  logic [OCC_WIDTH-1:0]          occ_q, occ_d;

  logic      in_fire;
  logic      is_remove;
  logic      full;
  logic      empty;
  spq_ctrl_t ctrl;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_remove  = command_i == CMD_REMOVE;
  assign full       = count_q == CW'(DEPTH);
  assign empty      = count_q == '0;
  assign ctrl.ins   = in_fire && !is_remove && !full;
  assign ctrl.rem   = in_fire && is_remove && !empty;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VALUE_WIDTH-1:0] left_value;
    logic                          left_greater;
    logic signed [VALUE_WIDTH-1:0] right_value;

    if (i == 0) begin : g_first
      assign left_value   = value_i;
      assign left_greater = 1'b0;
    end else begin : g_mid
      assign left_value   = cell_value[i-1];
      assign left_greater = cell_greater[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_value = cell_value[i];
    end else begin : g_inner
      assign right_value = cell_value[i+1];
    end

    spq_cell #(
      .IDX (i),
      .VW  (VALUE_WIDTH),
      .CW  (CW)
    ) u_cell (
      .clk_i          (clk_i),
      .ctrl_i         (ctrl),
      .count_i        (count_q),
      .value_i        (value_i),
      .left_value_i   (left_value),
      .left_greater_i (left_greater),
      .right_value_i  (right_value),
      .value_o        (cell_value[i]),
      .greater_o      (cell_greater[i])
    );
  end

  always_comb begin
    count_d   = count_q;
    removed_d = '0;
    status_d  = ST_DONE;
    if (ctrl.ins) begin
      count_d = count_q + 1'b1;
    end else if (ctrl.rem) begin
      count_d   = count_q - 1'b1;
      removed_d = cell_value[0];
    end else if (is_remove) begin
      status_d = ST_EMPTY;
    end else begin
      status_d = ST_FULL;
    end
    occ_d = OCC_WIDTH'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      removed_q <= removed_d;
      status_q  <= status_d;
      occ_q     <= occ_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign removed_value_o = removed_q;
  assign status_o        = status_q;
  assign occupancy_o     = occ_q;

  `SPQ_ASSERT(a_count_bound, count_q <= CW'(DEPTH), "count above depth")
  `SPQ_ASSERT_IMP(a_occ_match, out_valid_q, occ_q == OCC_WIDTH'(count_q), "occupancy mismatch")
  `SPQ_ASSERT_IMP(a_full_status, out_valid_q && status_q == ST_FULL, full, "full status, not full")
  `SPQ_ASSERT_IMP(a_head_order, count_q >= CW'(2), cell_value[0] <= cell_value[1], "head order")
  `SPQ_ASSERT_NXT(a_ins_count, ctrl.ins, count_q == $past(count_q) + 1'b1, "insert count")

endmodule

FILE: rtl/spq_cell.sv
`timescale 1ns / 1ps
module spq_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned VW  = spq_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned CW  = $clog2(spq_pkg::DEPTH_DEF + 1)
) (
  input  logic                 clk_i,
  input  spq_pkg::spq_ctrl_t   ctrl_i,
  input  logic [CW-1:0]        count_i,
  input  logic signed [VW-1:0] value_i,
  input  logic signed [VW-1:0] left_value_i,
  input  logic                 left_greater_i,
  input  logic signed [VW-1:0] right_value_i,
  output logic signed [VW-1:0] value_o,
  output logic                 greater_o
);
  import spq_pkg::*;

  logic signed [VW-1:0] value_q, value_d;
  logic                 occ;
  logic                 at_count;

  assign occ       = CW'(IDX) < count_i;
  assign at_count  = CW'(IDX) == count_i;
  assign greater_o = occ && (value_q > value_i);
  assign value_o   = value_q;

  always_comb begin
    value_d = value_q;
    if (ctrl_i.ins && (greater_o || at_count)) begin
      value_d = left_greater_i ? left_value_i : value_i;
    end else if (ctrl_i.rem) begin
      value_d = right_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule
